>>> rtl/page_watch_bitmap_macros.svh
// Assertion macros shared by the page watch bitmap RTL.
`ifndef PAGE_WATCH_BITMAP_MACROS_SVH
`define PAGE_WATCH_BITMAP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PWB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PWB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pwb_pkg.sv
// Package with command codes, field widths and parameter defaults of the page watch bitmap.
`timescale 1ns / 1ps
`default_nettype none
package pwb_pkg;

  localparam int unsigned ADDR_BITS_DEF  = 32;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IN_ADDR_W = 48;
  localparam int unsigned SIZE_W    = 41;
  localparam int unsigned MAP_W     = 64;
  localparam int unsigned BIT_IDX_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_WATCH   = 2'd0,
    CMD_UNWATCH = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_e;

endpackage
`default_nettype wire

>>> rtl/pwb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pwb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

>>> rtl/page_watch_bitmap.sv
// Page watch bitmap: read-watch, write-watch and candidate page maps in one word RAM.
//
// Keeps one bit per guest page in three maps (read-watch, write-watch, sticky
// candidate), stored side by side as 64-page words in a single RAM of
// 2^(ADDR_BITS-PAGE_SHIFT-6) words (two words when there are 64 pages or fewer).
// After reset the block sweeps that RAM to zero, one word per cycle; commands
// are held off during the sweep, configuration writes are taken at any time.
// A query goes from acceptance to its result beat through decode, RAM read,
// bit select and the result stage, which waits while the output is stalled.
// A watch or unwatch steps through each 64-page word it touches in turn,
// since each word is read, masked and written back through the RAM's single
// write port; ignored commands and queries outside the space skip the RAM.
// One command is in flight at a time; a finished result waits in the output
// register while the next command is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "page_watch_bitmap_macros.svh"
module page_watch_bitmap #(
  parameter int unsigned ADDR_BITS  = pwb_pkg::ADDR_BITS_DEF,
  parameter int unsigned PAGE_SHIFT = pwb_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [pwb_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [pwb_pkg::IN_ADDR_W-1:0] address_i,
  input  wire logic [pwb_pkg::SIZE_W-1:0]    range_size_i,
  input  wire logic                         access_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              tracked_o,
  output logic                              candidate_o,
  output logic                              done_res_o
);

  import pwb_pkg::*;

  localparam int unsigned PB     = ADDR_BITS - PAGE_SHIFT;
  localparam int unsigned WIDX_W = (PB > BIT_IDX_W) ? (PB - BIT_IDX_W) : 1;
  localparam int unsigned WORDS  = 1 << WIDX_W;
  localparam int unsigned SUM_W  = SIZE_W + 1;
  localparam int unsigned RAM_W  = 3 * MAP_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SETUP = 5'b00100,
    S_RUN   = 5'b01000,
    S_HOLD  = 5'b10000
  } state_e;

  function automatic logic [WIDX_W-1:0] word_of(input logic [PB-1:0] page);
    logic [PB+BIT_IDX_W-1:0] ext;
    ext = {{BIT_IDX_W{1'b0}}, page} >> BIT_IDX_W;
    return ext[WIDX_W-1:0];
  endfunction

  function automatic logic [BIT_IDX_W-1:0] bit_of(input logic [PB-1:0] page);
    logic [PB+BIT_IDX_W-1:0] ext;
    ext = {{BIT_IDX_W{1'b0}}, page};
    return ext[BIT_IDX_W-1:0];
  endfunction

  // control state
  state_e             state_q, state_d;
  logic               enable_q;
  logic [WIDX_W-1:0]  clr_w_q, clr_w_d;
  logic               out_valid_q, out_valid_d;
  logic               upd_q, upd_d;
  logic               qry_q, qry_d;
  logic [WIDX_W-1:0]  cur_w_q, cur_w_d;

  // payload
  cmd_e               cmd_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic               oob_q;
  logic [SIZE_W-1:0]  sizem1_q;
  logic               size_zero_q;
  logic               access_q;
  logic [WIDX_W-1:0]  first_w_q, last_w_q;
  logic [BIT_IDX_W-1:0] lo_bit_q, hi_bit_q;
  logic               res_tracked_q, res_tracked_d;
  logic               res_cand_q, res_cand_d;
  logic               out_tracked_q, out_cand_q;

  // datapath
  logic               in_acc, out_free, out_load;
  logic [SUM_W-1:0]   sum;
  logic               clamp;
  logic [ADDR_BITS-1:0] last_addr;
  logic [PB-1:0]      pg_first, pg_last;
  logic [WIDX_W-1:0]  start_w;
  logic               setup_upd, setup_qry, range_cmd;
  logic [MAP_W-1:0]   lo_mask, hi_mask, mask;
  logic [MAP_W-1:0]   rd_read, rd_write, rd_cand;
  logic [MAP_W-1:0]   nw_read, nw_write, nw_cand;
  logic [RAM_W-1:0]   rd_data, wr_data;
  logic               rd_en, wr_en;
  logic [WIDX_W-1:0]  rd_addr, wr_addr;
  logic [BIT_IDX_W-1:0] q_bit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_HOLD) && out_free;

  // range decode, used in the setup cycle
  assign sum        = SUM_W'(addr_q) + SUM_W'(sizem1_q);
  assign clamp      = |sum[SUM_W-1:ADDR_BITS];
  assign last_addr  = clamp ? {ADDR_BITS{1'b1}} : sum[ADDR_BITS-1:0];
  assign pg_first   = addr_q[ADDR_BITS-1:PAGE_SHIFT];
  assign pg_last    = last_addr[ADDR_BITS-1:PAGE_SHIFT];
  assign start_w    = word_of(pg_first);
  assign range_cmd  = (cmd_q == CMD_WATCH) || (cmd_q == CMD_UNWATCH);
  assign setup_upd  = range_cmd && enable_q && !size_zero_q && !oob_q;
  assign setup_qry  = (cmd_q == CMD_QUERY) && !oob_q;

  // word mask and read-modify-write
  assign lo_mask = (cur_w_q == first_w_q) ? ({MAP_W{1'b1}} << lo_bit_q) : {MAP_W{1'b1}};
  assign hi_mask = (cur_w_q == last_w_q)
                 ? ({MAP_W{1'b1}} >> (BIT_IDX_W'(MAP_W - 1) - hi_bit_q)) : {MAP_W{1'b1}};
  assign mask    = lo_mask & hi_mask;

  assign rd_read  = rd_data[MAP_W-1:0];
  assign rd_write = rd_data[2*MAP_W-1:MAP_W];
  assign rd_cand  = rd_data[3*MAP_W-1:2*MAP_W];
  assign q_bit    = bit_of(pg_first);

  always_comb begin
    nw_read  = rd_read;
    nw_write = rd_write;
    nw_cand  = rd_cand;
    if (cmd_q == CMD_WATCH) begin
      nw_cand = rd_cand | mask;
      if (access_q) begin
        nw_write = rd_write | mask;
      end else begin
        nw_read = rd_read | mask;
      end
    end else begin
      if (access_q) begin
        nw_write = rd_write & ~mask;
      end else begin
        nw_read = rd_read & ~mask;
      end
    end
  end

  assign wr_en   = (state_q == S_CLEAR) || ((state_q == S_RUN) && upd_q);
  assign wr_addr = (state_q == S_CLEAR) ? clr_w_q : cur_w_q;
  assign wr_data = (state_q == S_CLEAR) ? '0 : {nw_cand, nw_write, nw_read};
  assign rd_en   = ((state_q == S_SETUP) && (setup_upd || setup_qry))
                 || ((state_q == S_RUN) && upd_q && (cur_w_q != last_w_q));
  assign rd_addr = (state_q == S_SETUP) ? start_w : (cur_w_q + WIDX_W'(1));

  pwb_ram #(
    .WIDTH(RAM_W),
    .DEPTH(WORDS)
  ) u_map_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d       = state_q;
    clr_w_d       = clr_w_q;
    upd_d         = upd_q;
    qry_d         = qry_q;
    cur_w_d       = cur_w_q;
    res_tracked_d = res_tracked_q;
    res_cand_d    = res_cand_q;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        clr_w_d = clr_w_q + WIDX_W'(1);
        if (clr_w_q == {WIDX_W{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        upd_d         = setup_upd;
        qry_d         = setup_qry;
        cur_w_d       = start_w;
        res_tracked_d = 1'b0;
        res_cand_d    = 1'b0;
        state_d       = (setup_upd || setup_qry) ? S_RUN : S_HOLD;
      end
      S_RUN: begin
        if (qry_q) begin
          res_tracked_d = access_q ? rd_write[q_bit] : rd_read[q_bit];
          res_cand_d    = rd_cand[q_bit];
          state_d       = S_HOLD;
        end else if (cur_w_q == last_w_q) begin
          state_d = S_HOLD;
        end else begin
          // advance to the word already being read
          cur_w_d = cur_w_q + WIDX_W'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      enable_q      <= 1'b0;
      clr_w_q       <= '0;
      out_valid_q   <= 1'b0;
      upd_q         <= 1'b0;
      qry_q         <= 1'b0;
      cur_w_q       <= '0;
      res_tracked_q <= 1'b0;
      res_cand_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_w_q       <= clr_w_d;
      out_valid_q   <= out_valid_d;
      upd_q         <= upd_d;
      qry_q         <= qry_d;
      cur_w_q       <= cur_w_d;
      res_tracked_q <= res_tracked_d;
      res_cand_q    <= res_cand_d;
      if (cfg_valid_i && cfg_ready_o) begin
        enable_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q       <= cmd_e'(cmd_i);
      addr_q      <= address_i[ADDR_BITS-1:0];
      oob_q       <= |address_i[IN_ADDR_W-1:ADDR_BITS];
      sizem1_q    <= range_size_i - SIZE_W'(1);
      size_zero_q <= (range_size_i == '0);
      access_q    <= access_i;
    end
    if (state_q == S_SETUP) begin
      first_w_q <= start_w;
      last_w_q  <= word_of(pg_last);
      lo_bit_q  <= bit_of(pg_first);
      hi_bit_q  <= bit_of(pg_last);
    end
    if (out_load) begin
      out_tracked_q <= res_tracked_q;
      out_cand_q    <= res_cand_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tracked_o   = out_tracked_q;
  assign candidate_o = out_cand_q;
  assign done_res_o  = 1'b1;

  `PWB_ASSERT_NOW(a_wr_only_clear_run, wr_en, (state_q == S_CLEAR) || (state_q == S_RUN),
    "map RAM written outside clear or update")
  `PWB_ASSERT_NOW(a_no_rw_collision, wr_en && rd_en, wr_addr != rd_addr,
    "read and write of the same map word in one cycle")
  `PWB_ASSERT_NOW(a_word_in_range, (state_q == S_RUN) && upd_q,
    (cur_w_q >= first_w_q) && (cur_w_q <= last_w_q), "update word outside its range")
  `PWB_ASSERT_NEXT(a_hold_loads_out, out_load, out_valid_q && (state_q == S_IDLE),
    "finished result not moved to the output register")

endmodule
`default_nettype wire
